>>> rtl/core/msbt_pkg.sv
`default_nettype none

package msbt_pkg;

    localparam int ADDR_W_DEF = 20;
    localparam int OUT_ADDR_W = 20;
    localparam int LEN_W      = 21;
    localparam int ERR_W      = 21;
    localparam int BYTE_W     = 8;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(20'h10000);
    localparam logic [ERR_W-1:0] ERR_MAX   = '1;
    localparam logic [BYTE_W-1:0] PAT_MUL  = 8'h9D;
    localparam logic [BYTE_W-1:0] PAT_XOR  = 8'h5A;

    localparam logic [0:0] REG_TEST_LENGTH = 1'b0;

    localparam logic OP_START = 1'b0;
    localparam logic OP_DONE  = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_WRITE = 2'd1,
        PH_READ  = 2'd2,
        PH_DONE  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    typedef struct packed {
        logic              operation;
        logic [BYTE_W-1:0] read_data;
    } t_in_item;

    typedef struct packed {
        t_cmd                  cmd_kind;
        logic [OUT_ADDR_W-1:0] cmd_addr;
        logic [BYTE_W-1:0]     cmd_wdata;
        logic                  done_res;
        logic                  pass;
        logic [ERR_W-1:0]      error_count;
        logic [OUT_ADDR_W-1:0] first_fail_addr;
        logic [BYTE_W-1:0]     first_rd_byte;
        logic [BYTE_W-1:0]     first_exp_byte;
        logic [1:0]            fail_bank;
        logic [8:0]            fail_row;
        logic [8:0]            fail_col;
    } t_out_item;

    function automatic logic [BYTE_W-1:0] pattern_of(input logic [BYTE_W-1:0] a);
        logic [BYTE_W-1:0] prod;
        prod = BYTE_W'(a * PAT_MUL);
        return prod ^ PAT_XOR;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/msbt_queue.sv
`default_nettype none

module msbt_queue #(
    parameter type t_data = logic
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    output logic       o_full,
    input  wire t_data i_data,
    output logic       o_empty,
    input  wire logic  i_pop,
    output t_data      o_data
);

    t_data      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/msbt_cfg.sv
`default_nettype none

module msbt_cfg
    import msbt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output logic      [LEN_W-1:0]  o_test_length
);

    logic [LEN_W-1:0] r_test_length;
    logic             wr_len;

    assign pready        = 1'b1;
    assign wr_len        = psel && penable && pwrite && (paddr[2] == REG_TEST_LENGTH);
    assign o_test_length = r_test_length;

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_TEST_LENGTH) begin
            prdata = APB_DW'(r_test_length);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_test_length <= LEN_RESET;
        end else if (wr_len) begin
            r_test_length <= pwdata[LEN_W-1:0];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/msbt_back.sv
`default_nettype none

module msbt_back
    import msbt_pkg::*;
#(
    parameter int ADDR_W = ADDR_W_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [LEN_W-1:0] i_test_length,
    input  wire logic             i_in_empty,
    output logic                  o_in_pop,
    input  wire t_in_item         i_in_item,
    output logic                  o_empty,
    input  wire logic             i_pop,
    output t_out_item             o_result
);

    localparam int LW = (ADDR_W + 1 > LEN_W) ? ADDR_W + 1 : LEN_W;

    t_phase                r_phase;
    t_phase                n_phase;
    logic [ADDR_W:0]       r_cnt;
    logic [ADDR_W:0]       n_cnt;
    logic [ERR_W-1:0]      r_errs;
    logic [ERR_W-1:0]      n_errs;
    logic                  r_seen;
    logic                  n_seen;
    logic [OUT_ADDR_W-1:0] r_cap_addr;
    logic [OUT_ADDR_W-1:0] n_cap_addr;
    logic [BYTE_W-1:0]     r_cap_got;
    logic [BYTE_W-1:0]     n_cap_got;
    logic [BYTE_W-1:0]     r_cap_want;
    logic [BYTE_W-1:0]     n_cap_want;

    logic                  out_full;
    logic                  fire;
    logic                  is_start;
    logic [LW-1:0]         len_raw;
    logic [LW-1:0]         len_lim;
    logic [LW-1:0]         len;
    logic [ADDR_W:0]       cnt_inc;
    logic [LW-1:0]         cnt_ext;
    logic [LW-1:0]         inc_ext;
    logic                  more;
    logic [BYTE_W-1:0]     want;
    logic                  mismatch;
    logic                  do_report;
    t_out_item             res;

    assign fire     = !i_in_empty && !out_full;
    assign o_in_pop = fire;
    assign is_start = (i_in_item.operation == OP_START);

    assign len_raw = LW'(i_test_length);
    assign len_lim = LW'(1) << ADDR_W;
    always_comb begin
        len = len_raw;
        if (len_raw == '0) begin
            len = LW'(1);
        end else if (len_raw > len_lim) begin
            len = len_lim;
        end
    end

    assign cnt_inc  = r_cnt + 1'b1;
    assign cnt_ext  = LW'(r_cnt);
    assign inc_ext  = LW'(cnt_inc);
    assign more     = (inc_ext < len);
    assign want     = pattern_of(r_cnt[BYTE_W-1:0]);
    assign mismatch = (i_in_item.read_data != want);

    always_comb begin
        n_phase = r_phase;
        if (fire) begin
            if (is_start) begin
                n_phase = PH_WRITE;
            end else begin
                unique case (r_phase)
                    PH_WRITE: if (!more) n_phase = PH_READ;
                    PH_READ:  if (!more) n_phase = PH_DONE;
                    PH_IDLE:  n_phase = PH_IDLE;
                    PH_DONE:  n_phase = PH_DONE;
                endcase
            end
        end
    end

    always_comb begin
        n_cnt      = r_cnt;
        n_errs     = r_errs;
        n_seen     = r_seen;
        n_cap_addr = r_cap_addr;
        n_cap_got  = r_cap_got;
        n_cap_want = r_cap_want;
        do_report  = 1'b0;
        res        = '0;
        res.cmd_kind = CMD_NONE;
        if (fire) begin
            if (is_start) begin
                n_cnt         = '0;
                n_errs        = '0;
                n_seen        = 1'b0;
                n_cap_addr    = '0;
                n_cap_got     = '0;
                n_cap_want    = '0;
                res.cmd_kind  = CMD_WRITE;
                res.cmd_wdata = pattern_of('0);
            end else begin
                unique case (r_phase)
                    PH_WRITE: begin
                        if (more) begin
                            n_cnt         = cnt_inc;
                            res.cmd_kind  = CMD_WRITE;
                            res.cmd_addr  = inc_ext[OUT_ADDR_W-1:0];
                            res.cmd_wdata = pattern_of(cnt_inc[BYTE_W-1:0]);
                        end else begin
                            n_cnt        = '0;
                            res.cmd_kind = CMD_READ;
                        end
                    end
                    PH_READ: begin
                        if (mismatch) begin
                            if (!r_seen) begin
                                n_seen     = 1'b1;
                                n_cap_addr = cnt_ext[OUT_ADDR_W-1:0];
                                n_cap_got  = i_in_item.read_data;
                                n_cap_want = want;
                            end
                            if (r_errs != ERR_MAX) begin
                                n_errs = r_errs + 1'b1;
                            end
                        end
                        if (more) begin
                            n_cnt        = cnt_inc;
                            res.cmd_kind = CMD_READ;
                            res.cmd_addr = inc_ext[OUT_ADDR_W-1:0];
                        end else begin
                            do_report = 1'b1;
                        end
                    end
                    PH_DONE: do_report = 1'b1;
                    PH_IDLE: do_report = 1'b0;
                endcase
            end
        end
        if (do_report) begin
            res.done_res = 1'b1;
            res.pass     = !n_seen;
            if (n_seen) begin
                res.error_count     = n_errs;
                res.first_fail_addr = n_cap_addr;
                res.first_rd_byte   = n_cap_got;
                res.first_exp_byte  = n_cap_want;
                res.fail_bank       = n_cap_addr[10:9];
                res.fail_row        = n_cap_addr[19:11];
                res.fail_col        = n_cap_addr[8:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_cnt      <= '0;
            r_errs     <= '0;
            r_seen     <= 1'b0;
            r_cap_addr <= '0;
            r_cap_got  <= '0;
            r_cap_want <= '0;
        end else begin
            r_phase    <= n_phase;
            r_cnt      <= n_cnt;
            r_errs     <= n_errs;
            r_seen     <= n_seen;
            r_cap_addr <= n_cap_addr;
            r_cap_got  <= n_cap_got;
            r_cap_want <= n_cap_want;
        end
    end

    msbt_queue #(
        .t_data (t_out_item)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .o_full  (out_full),
        .i_data  (res),
        .o_empty (o_empty),
        .i_pop   (i_pop),
        .o_data  (o_result)
    );

endmodule

`default_nettype wire

>>> rtl/core/memory_write_read_self_test_top.sv
`default_nettype none

// channel  | direction | handshake               | payload
// ---------+-----------+-------------------------+-----------------------------
// item     | in        | push / full             | i_item   (t_in_item)
// result   | out       | empty / pop             | o_result (t_out_item)
// config   | in        | psel penable pwrite     | paddr pwdata prdata pready
//
// One item per cycle while results are popped; each item reaches the result
// ports via the input queue, then a sequencer step into the result queue.
// Both queues hold two items, so a stalled pop backs up into full.
// Synchronous active-low reset; test_length resets to 65536, phase to idle.

module memory_write_read_self_test_top
    import msbt_pkg::*;
#(
    parameter int ADDR_W = ADDR_W_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    input  wire logic              push,
    output logic                   full,
    input  wire t_in_item          i_item,
    output logic                   empty,
    input  wire logic              pop,
    output t_out_item              o_result
);

    logic [LEN_W-1:0] test_length;
    logic             in_empty;
    logic             in_pop;
    t_in_item         in_head;

    msbt_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_test_length (test_length)
    );

    msbt_queue #(
        .t_data (t_in_item)
    ) u_in_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_data  (i_item),
        .o_empty (in_empty),
        .i_pop   (in_pop),
        .o_data  (in_head)
    );

    msbt_back #(
        .ADDR_W (ADDR_W)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_test_length (test_length),
        .i_in_empty    (in_empty),
        .o_in_pop      (in_pop),
        .i_in_item     (in_head),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_result      (o_result)
    );

endmodule

`default_nettype wire
